// ===== hw/rtl/flgq_pkg.sv =====
`default_nettype none
package flgq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int ID_WIDTH    = 8;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W       = IDX_W + 1;

    typedef enum logic [1:0] {
        KIND_PUSH   = 2'd0,
        KIND_POP    = 2'd1,
        KIND_CANCEL = 2'd2,
        KIND_CLAIM  = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_FULL      = 2'd1,
        STAT_UNQUEUED  = 2'd2,
        STAT_NOT_FOUND = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_POP_HEAD,
        S_DRAIN,
        S_SRCH,
        S_FIN
    } state_t;

    typedef struct packed {
        kind_t               kind;
        logic [ID_WIDTH-1:0] requester_id;
        logic                cancelled;
    } in_t;

    typedef struct packed {
        logic                grant_valid;
        logic [ID_WIDTH-1:0] grant_id;
        logic                enqueued;
        logic                owned;
        logic                queue_empty;
        status_t             status;
    } out_t;

    function automatic logic [IDX_W-1:0] slot_add(input logic [IDX_W-1:0] a,
                                                   input logic [IDX_W-1:0] b);
        logic [SUM_W-1:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        if (sum >= SUM_W'(QUEUE_DEPTH)) begin
            sum = sum - SUM_W'(QUEUE_DEPTH);
        end
        return sum[IDX_W-1:0];
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/flgq_ram.sv =====
`default_nettype none
module flgq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/fifo_lock_grant_queue_unit.sv =====
// First-come lock queue with cancellation.
// Input channel s_valid/s_ready/s_data carries one item: push (request),
// pop (release), cancel (mark a waiting entry) or claim (record owner).
// Result channel m_valid/m_ready/m_data returns exactly one item per input.
// One item is worked on at a time; s_ready is high whenever no item is in work.
// Each item ends in S_FIN, which loads its result into the output register:
//   push, claim, pop or cancel on an empty queue: straight to S_FIN.
//   pop: the head is read in S_POP_HEAD; a requester that is neither the
//   head nor flagged cancelled gets STAT_UNQUEUED. A pop by the head drops
//   it, and S_DRAIN drops dead or cancelled entries behind it until a live
//   one is granted or the queue ends empty.
//   cancel, or pop by a waiting cancelled requester: S_SRCH walks from the head.
// The next item can be accepted from the cycle in which m_valid rises; the id walk
// advances one slot per cycle through the RAM's registered read port.
// A finished result sits in the output register until taken; a new item is
// accepted meanwhile, and its result waits in the unit until the register
// frees, so a stalled receiver holds back at most one item in work.
// aresetn (synchronous, active low) empties the queue, clears the owner and
// drops any pending result; the id RAM itself is not cleared.
`default_nettype none
module fifo_lock_grant_queue_unit (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_valid,
    output logic                s_ready,
    input  wire flgq_pkg::in_t  s_data,
    output logic                m_valid,
    input  wire logic           m_ready,
    output flgq_pkg::out_t      m_data
);

    localparam int IDX_W = flgq_pkg::IDX_W;
    localparam int CNT_W = flgq_pkg::CNT_W;
    localparam int ID_W  = flgq_pkg::ID_WIDTH;
    localparam int DEPTH = flgq_pkg::QUEUE_DEPTH;

    flgq_pkg::state_t         state_reg, state_next;
    flgq_pkg::kind_t          kind_reg, kind_next;
    logic [ID_W-1:0]          req_reg, req_next;
    logic                     cin_reg, cin_next;
    logic [IDX_W-1:0]         k_reg, k_next;
    logic [IDX_W-1:0]         head_reg, head_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic [ID_W-1:0]          owner_reg, owner_next;
    logic [DEPTH-1:0]         live_reg, live_next;
    logic [DEPTH-1:0]         canc_reg, canc_next;
    logic                     res_gv_reg, res_gv_next;
    logic [ID_W-1:0]          res_gid_reg, res_gid_next;
    logic                     res_enq_reg, res_enq_next;
    flgq_pkg::status_t        res_stat_reg, res_stat_next;
    logic                     m_valid_reg, m_valid_next;
    flgq_pkg::out_t           m_data_reg, m_data_next;

    logic                     ram_we;
    logic [IDX_W-1:0]         ram_waddr;
    logic                     ram_re;
    logic [IDX_W-1:0]         ram_raddr;
    logic [ID_W-1:0]          ram_rdata;

    logic [IDX_W-1:0]         tail;
    logic [IDX_W-1:0]         head_inc;
    logic [IDX_W-1:0]         cur_slot;
    logic                     hit;

    flgq_ram #(
        .WIDTH(ID_W),
        .DEPTH(DEPTH)
    ) u_id_ram (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(s_data.requester_id),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign tail     = flgq_pkg::slot_add(head_reg, count_reg[IDX_W-1:0]);
    assign head_inc = flgq_pkg::slot_add(head_reg, IDX_W'(1));
    assign cur_slot = (state_reg == flgq_pkg::S_SRCH) ?
                      flgq_pkg::slot_add(head_reg, k_reg) : head_reg;
    assign hit      = live_reg[cur_slot] && (ram_rdata == req_reg);

    assign s_ready = (state_reg == flgq_pkg::S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= flgq_pkg::S_IDLE;
            head_reg    <= '0;
            count_reg   <= '0;
            owner_reg   <= '0;
            live_reg    <= '0;
            canc_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            count_reg   <= count_next;
            owner_reg   <= owner_next;
            live_reg    <= live_next;
            canc_reg    <= canc_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg     <= kind_next;
        req_reg      <= req_next;
        cin_reg      <= cin_next;
        k_reg        <= k_next;
        res_gv_reg   <= res_gv_next;
        res_gid_reg  <= res_gid_next;
        res_enq_reg  <= res_enq_next;
        res_stat_reg <= res_stat_next;
        m_data_reg   <= m_data_next;
    end

    always_comb begin
        state_next    = state_reg;
        kind_next     = kind_reg;
        req_next      = req_reg;
        cin_next      = cin_reg;
        k_next        = k_reg;
        head_next     = head_reg;
        count_next    = count_reg;
        owner_next    = owner_reg;
        live_next     = live_reg;
        canc_next     = canc_reg;
        res_gv_next   = res_gv_reg;
        res_gid_next  = res_gid_reg;
        res_enq_next  = res_enq_reg;
        res_stat_next = res_stat_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_data_next   = m_data_reg;
        ram_we        = 1'b0;
        ram_waddr     = tail;
        ram_re        = 1'b0;
        ram_raddr     = head_reg;

        case (state_reg)
            flgq_pkg::S_IDLE: begin
                if (s_valid) begin
                    kind_next     = s_data.kind;
                    req_next      = s_data.requester_id;
                    cin_next      = s_data.cancelled;
                    k_next        = '0;
                    res_gv_next   = 1'b0;
                    res_gid_next  = '0;
                    res_enq_next  = 1'b0;
                    res_stat_next = flgq_pkg::STAT_OK;
                    state_next    = flgq_pkg::S_FIN;
                    case (s_data.kind)
                        flgq_pkg::KIND_PUSH: begin
                            if (count_reg == '0) begin
                                res_gv_next  = 1'b1;
                                res_gid_next = s_data.requester_id;
                            end
                            if (!s_data.cancelled) begin
                                if (count_reg == CNT_W'(DEPTH)) begin
                                    res_stat_next = flgq_pkg::STAT_FULL;
                                end else begin
                                    ram_we          = 1'b1;
                                    live_next[tail] = 1'b1;
                                    canc_next[tail] = 1'b0;
                                    count_next      = count_reg + CNT_W'(1);
                                    res_enq_next    = 1'b1;
                                end
                            end
                        end
                        flgq_pkg::KIND_POP: begin
                            if (count_reg == '0) begin
                                res_stat_next = s_data.cancelled ? flgq_pkg::STAT_OK :
                                                flgq_pkg::STAT_UNQUEUED;
                            end else begin
                                ram_re     = 1'b1;
                                state_next = flgq_pkg::S_POP_HEAD;
                            end
                        end
                        flgq_pkg::KIND_CANCEL: begin
                            if (count_reg == '0) begin
                                res_stat_next = flgq_pkg::STAT_NOT_FOUND;
                            end else begin
                                ram_re     = 1'b1;
                                state_next = flgq_pkg::S_SRCH;
                            end
                        end
                        flgq_pkg::KIND_CLAIM: begin
                            owner_next = s_data.requester_id;
                        end
                        default: begin
                            state_next = flgq_pkg::S_FIN;
                        end
                    endcase
                end
            end

            flgq_pkg::S_POP_HEAD: begin
                if (hit) begin
                    live_next[head_reg] = 1'b0;
                    canc_next[head_reg] = 1'b0;
                    head_next           = head_inc;
                    count_next          = count_reg - CNT_W'(1);
                    owner_next          = '0;
                    if (count_reg > CNT_W'(1)) begin
                        ram_re     = 1'b1;
                        ram_raddr  = head_inc;
                        state_next = flgq_pkg::S_DRAIN;
                    end else begin
                        state_next = flgq_pkg::S_FIN;
                    end
                end else if (!cin_reg) begin
                    res_stat_next = flgq_pkg::STAT_UNQUEUED;
                    state_next    = flgq_pkg::S_FIN;
                end else begin
                    // rdata still holds the head; walk from slot zero
                    state_next = flgq_pkg::S_SRCH;
                end
            end

            flgq_pkg::S_DRAIN: begin
                if (!live_reg[head_reg] || canc_reg[head_reg]) begin
                    live_next[head_reg] = 1'b0;
                    canc_next[head_reg] = 1'b0;
                    head_next           = head_inc;
                    count_next          = count_reg - CNT_W'(1);
                    if (count_reg > CNT_W'(1)) begin
                        ram_re    = 1'b1;
                        ram_raddr = head_inc;
                    end else begin
                        state_next = flgq_pkg::S_FIN;
                    end
                end else begin
                    res_gv_next  = 1'b1;
                    res_gid_next = ram_rdata;
                    state_next   = flgq_pkg::S_FIN;
                end
            end

            flgq_pkg::S_SRCH: begin
                if (hit) begin
                    if (kind_reg == flgq_pkg::KIND_CANCEL) begin
                        canc_next[cur_slot] = 1'b1;
                    end else begin
                        live_next[cur_slot] = 1'b0;
                        canc_next[cur_slot] = 1'b0;
                    end
                    state_next = flgq_pkg::S_FIN;
                end else if (CNT_W'(k_reg) + CNT_W'(1) == count_reg) begin
                    res_stat_next = flgq_pkg::STAT_NOT_FOUND;
                    state_next    = flgq_pkg::S_FIN;
                end else begin
                    ram_re    = 1'b1;
                    ram_raddr = flgq_pkg::slot_add(head_reg, k_reg + IDX_W'(1));
                    k_next    = k_reg + IDX_W'(1);
                end
            end

            flgq_pkg::S_FIN: begin
                if (!m_valid_reg || m_ready) begin
                    m_data_next.grant_valid = res_gv_reg;
                    m_data_next.grant_id    = res_gid_reg;
                    m_data_next.enqueued    = res_enq_reg;
                    m_data_next.owned       = (req_reg != '0) && (owner_reg == req_reg);
                    m_data_next.queue_empty = (count_reg == '0);
                    m_data_next.status      = res_stat_reg;
                    m_valid_next            = 1'b1;
                    state_next              = flgq_pkg::S_IDLE;
                end
            end

            default: begin
                state_next = flgq_pkg::S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== hw/rtl/flgq_checker.sv =====
`default_nettype none
module flgq_checker (
    input wire logic           aclk,
    input wire logic           aresetn,
    input wire logic           s_valid,
    input wire logic           s_ready,
    input wire logic           m_valid,
    input wire logic           m_ready,
    input wire flgq_pkg::out_t m_data
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result item changed while stalled");

    a_no_grant_id: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.grant_valid |-> m_data.grant_id == '0)
        else $error("grant id set without grant");

    a_enq_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.enqueued |->
            m_data.status == flgq_pkg::STAT_OK && !m_data.queue_empty)
        else $error("enqueued item left queue empty or flagged");

    a_full_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status == flgq_pkg::STAT_FULL |->
            !m_data.grant_valid && !m_data.enqueued && !m_data.queue_empty)
        else $error("full-queue drop reported grant or enqueue");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second item accepted while one is in work");

endmodule

bind fifo_lock_grant_queue_unit flgq_checker u_flgq_checker (
    .aclk   (aclk),
    .aresetn(aresetn),
    .s_valid(s_valid),
    .s_ready(s_ready),
    .m_valid(m_valid),
    .m_ready(m_ready),
    .m_data (m_data)
);
`default_nettype wire
